/* design/rectr_pkg.sv */
// rectifier output block: shared widths, codes, state type and divider structs
// depends on nothing; used by every design file
`default_nettype none

package rectr_pkg;

    localparam int V_W      = 24;
    localparam int R_W      = 24;
    localparam int G_W      = 20;
    localparam int PIN_W    = 5;
    localparam int IDX_W    = 4;
    localparam int OUT_W    = 32;
    localparam int DIF_W    = 25;
    localparam int PROD_W   = 50;
    localparam int ACC_W    = 52;
    localparam int PG_W     = 45;
    localparam int DIV_CNT_W = 6;
    localparam int ENTRY_W  = V_W + R_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 2'd1;

    localparam logic [G_W-1:0]   GAIN_RESET = 20'd65536;
    localparam logic [R_W-1:0]   RES_MAX    = 24'hFFFFFF;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [1:0] RANGE_INSIDE = 2'd0;
    localparam logic [1:0] RANGE_BELOW  = 2'd1;
    localparam logic [1:0] RANGE_ABOVE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_RD_LO,
        ST_RD_HI,
        ST_SEG,
        ST_MUL_SEG,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_G,
        ST_MUL_R,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic signed [DIF_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* design/rectr_if.sv */
// item, result and configuration channels of the rectifier output block
// depends on rectr_pkg
`default_nettype none

interface rectr_item_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [rectr_pkg::IDX_W-1:0]      point_index;
    logic signed [rectr_pkg::V_W-1:0] point_voltage;
    logic [rectr_pkg::R_W-1:0]        point_resistance;
    logic signed [rectr_pkg::V_W-1:0] input_voltage;
    logic signed [rectr_pkg::V_W-1:0] output_current;

    modport source (output valid, command, point_index, point_voltage,
                    point_resistance, input_voltage, output_current, input ready);
    modport sink (input valid, command, point_index, point_voltage,
                  point_resistance, input_voltage, output_current, output ready);
endinterface

interface rectr_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [rectr_pkg::OUT_W-1:0] output_voltage;
    logic [rectr_pkg::R_W-1:0]          resistance_used;
    logic [rectr_pkg::IDX_W-1:0]        segment_used;
    logic [1:0]                         range_status;
    logic                               table_error;
    logic                               saturated;

    modport source (output valid, output_voltage, resistance_used, segment_used,
                    range_status, table_error, saturated, input ready);
    modport sink (input valid, output_voltage, resistance_used, segment_used,
                  range_status, table_error, saturated, output ready);
endinterface

interface rectr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rectr_pkg::CFG_IDX_W-1:0]     index;
    logic [rectr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/rectr_table_mem.sv */
// point table memory: voltage and resistance per entry, one port, registered read
// depends on rectr_pkg
`default_nettype none

module rectr_table_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [AW-1:0]                      addr,
    input  wire logic [rectr_pkg::ENTRY_W-1:0]      wdata,
    output logic      [rectr_pkg::ENTRY_W-1:0]      rdata
);

    logic [rectr_pkg::ENTRY_W-1:0] mem [DEPTH];

    // single port, read data valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* design/rectr_div.sv */
// iterative signed divider, one quotient bit a cycle, truncates toward zero
// depends on rectr_pkg
`default_nettype none

module rectr_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rectr_pkg::div_req_t req,
    output rectr_pkg::div_rsp_t      rsp
);

    localparam int PW = rectr_pkg::PROD_W;
    localparam int DW = rectr_pkg::DIF_W;
    localparam int CW = rectr_pkg::DIV_CNT_W;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [PW-1:0]       quo_reg, quo_next;
    logic [DW-1:0]       dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [DW:0]         rem_sh;
    logic [DW:0]         rem_sub;

    // one restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[PW-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(PW);
            rem_next  = '0;
            quo_next  = req.dividend[PW-1] ? PW'(-req.dividend) : PW'(req.dividend);
            dvs_next  = req.divisor[DW-1] ? DW'(-req.divisor) : DW'(req.divisor);
            neg_next  = req.dividend[PW-1] ^ req.divisor[DW-1];
        end
        else if (busy_reg)
        begin
            if (!rem_sub[DW])
            begin
                rem_next = rem_sub[DW-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

/* design/rectifier_output_with_table_resistance.sv */
// compute beat: a binary search over the table, each step a read state and a compare state,
// then four table reads, a segment step, the divider, the gain and resistance multiplies and
// rounding; a flat segment skips the divider, and below two points only the arithmetic runs
// one item in flight; a load beat leaves the block idle, ready for the next beat; after a
// compute, the next beat is taken the cycle after the result register loads, even while it waits
// reset clears control and config registers; table contents stay undefined until loaded
`default_nettype none

module rectifier_output_with_table_resistance #(
    parameter int TABLE_POINTS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rectr_item_if.sink     item,
    rectr_result_if.source result,
    rectr_cfg_if.sink      cfg
);

    localparam int IW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int NW = $clog2(TABLE_POINTS + 1);
    localparam int VW = rectr_pkg::V_W;
    localparam int RW = rectr_pkg::R_W;
    localparam int DW = rectr_pkg::DIF_W;
    localparam int PW = rectr_pkg::PROD_W;
    localparam int AW = rectr_pkg::ACC_W;
    localparam int GW = rectr_pkg::PG_W;

    rectr_pkg::state_t state_reg, state_next;

    logic [rectr_pkg::G_W-1:0]   gain_reg;
    logic [rectr_pkg::PIN_W-1:0] points_reg;

    logic signed [VW-1:0] u_reg, cur_reg;
    logic [IW-1:0]        lo_reg, hi_reg, nm1_reg;
    logic                 below_reg;
    logic [1:0]           status_reg;
    logic                 err_reg;
    logic signed [VW-1:0] v0_reg;
    logic [RW-1:0]        r0_reg;
    logic signed [DW-1:0] rdiff_reg, du_reg, dv_reg;
    logic signed [PW-1:0] prod_reg;
    logic [RW-1:0]        r_reg;
    logic signed [GW-1:0] pg_reg;
    logic signed [AW-1:0] acc_reg;

    logic                                  out_valid_reg;
    logic signed [rectr_pkg::OUT_W-1:0]    out_v_reg;
    logic [RW-1:0]                         out_r_reg;
    logic [rectr_pkg::IDX_W-1:0]           out_seg_reg;
    logic [1:0]                            out_status_reg;
    logic                                  out_err_reg;
    logic                                  out_sat_reg;

    logic                          mem_we;
    logic [IW-1:0]                 mem_addr;
    logic [IW-1:0]                 rd_addr;
    logic [rectr_pkg::ENTRY_W-1:0] mem_rdata;
    logic signed [VW-1:0]          rd_v;
    logic [RW-1:0]                 rd_r;

    rectr_pkg::div_req_t div_req;
    rectr_pkg::div_rsp_t div_rsp;

    logic          item_acc, load_ok, out_free, out_load;
    logic [NW-1:0] n_use;
    logic [IW-1:0] mid, lo_nx, hi_nx;
    logic          short_tab;
    logic signed [DW-1:0]   dv_c;
    logic signed [PW:0]     rsum;
    logic signed [GW-1:0]   pg_c;
    logic signed [48:0]     prc_c;
    logic signed [AW-1:0]   rnd_c;
    logic signed [AW-1:0]   vfull_c;

    // channel handshakes
    assign item_acc  = item.valid & item.ready;
    assign load_ok   = (32'(item.point_index) < TABLE_POINTS);
    assign out_free  = !out_valid_reg || result.ready;
    assign cfg.ready = 1'b1;

    // points in use, limited to the table size
    always_comb
    begin
        if (32'(points_reg) < TABLE_POINTS)
        begin
            n_use = NW'(points_reg);
        end
        else
        begin
            n_use = NW'(TABLE_POINTS);
        end
        short_tab = (n_use < NW'(2));
    end

    // one search step
    assign rd_v = $signed(mem_rdata[rectr_pkg::ENTRY_W-1:RW]);
    assign rd_r = mem_rdata[RW-1:0];
    assign mid  = IW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    always_comb
    begin
        lo_nx = lo_reg;
        hi_nx = hi_reg;
        if (u_reg <= rd_v)
        begin
            hi_nx = mid;
        end
        else
        begin
            lo_nx = mid;
        end
    end

    assign dv_c = DW'(rd_v) - DW'(v0_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rectr_pkg::ST_IDLE:
            begin
                if (item_acc && item.command == rectr_pkg::CMD_COMPUTE)
                begin
                    if (short_tab)
                    begin
                        state_next = rectr_pkg::ST_MUL_G;
                    end
                    else if (n_use > NW'(2))
                    begin
                        state_next = rectr_pkg::ST_SRCH_RD;
                    end
                    else
                    begin
                        state_next = rectr_pkg::ST_RD_FIRST;
                    end
                end
            end
            rectr_pkg::ST_SRCH_RD:  state_next = rectr_pkg::ST_SRCH_CMP;
            rectr_pkg::ST_SRCH_CMP:
            begin
                if (hi_nx - lo_nx > IW'(1))
                begin
                    state_next = rectr_pkg::ST_SRCH_RD;
                end
                else
                begin
                    state_next = rectr_pkg::ST_RD_FIRST;
                end
            end
            rectr_pkg::ST_RD_FIRST: state_next = rectr_pkg::ST_RD_LAST;
            rectr_pkg::ST_RD_LAST:  state_next = rectr_pkg::ST_RD_LO;
            rectr_pkg::ST_RD_LO:    state_next = rectr_pkg::ST_RD_HI;
            rectr_pkg::ST_RD_HI:    state_next = rectr_pkg::ST_SEG;
            rectr_pkg::ST_SEG:
            begin
                if (dv_c == '0)
                begin
                    state_next = rectr_pkg::ST_MUL_G;
                end
                else
                begin
                    state_next = rectr_pkg::ST_MUL_SEG;
                end
            end
            rectr_pkg::ST_MUL_SEG:   state_next = rectr_pkg::ST_DIV_START;
            rectr_pkg::ST_DIV_START: state_next = rectr_pkg::ST_DIV_WAIT;
            rectr_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = rectr_pkg::ST_MUL_G;
                end
            end
            rectr_pkg::ST_MUL_G: state_next = rectr_pkg::ST_MUL_R;
            rectr_pkg::ST_MUL_R: state_next = rectr_pkg::ST_ROUND;
            rectr_pkg::ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = rectr_pkg::ST_IDLE;
                end
            end
            default: state_next = rectr_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item.ready    = 1'b0;
        rd_addr       = '0;
        div_req.start = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            rectr_pkg::ST_IDLE:      item.ready    = 1'b1;
            rectr_pkg::ST_SRCH_RD:   rd_addr       = mid;
            rectr_pkg::ST_RD_FIRST:  rd_addr       = '0;
            rectr_pkg::ST_RD_LAST:   rd_addr       = nm1_reg;
            rectr_pkg::ST_RD_LO:     rd_addr       = lo_reg;
            rectr_pkg::ST_RD_HI:     rd_addr       = lo_reg + 1'b1;
            rectr_pkg::ST_DIV_START: div_req.start = 1'b1;
            rectr_pkg::ST_ROUND:     out_load      = out_free;
            default:                 rd_addr       = '0;
        endcase
    end

    // table memory port
    assign mem_we   = item_acc && item.command == rectr_pkg::CMD_LOAD && load_ok;
    assign mem_addr = mem_we ? IW'(item.point_index) : rd_addr;

    rectr_table_mem #(
        .DEPTH (TABLE_POINTS),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata ({item.point_voltage, item.point_resistance}),
        .rdata (mem_rdata)
    );

    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = dv_reg;

    rectr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // arithmetic terms
    assign rsum    = (PW+1)'($signed({1'b0, r0_reg})) + (PW+1)'(div_rsp.quotient);
    assign pg_c    = GW'($signed({1'b0, gain_reg})) * GW'(u_reg);
    assign prc_c   = 49'($signed({1'b0, r_reg})) * 49'(cur_reg);
    assign rnd_c   = acc_reg + (AW'(1) <<< 19);
    assign vfull_c = rnd_c >>> 20;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rectr_pkg::ST_IDLE;
            gain_reg      <= rectr_pkg::GAIN_RESET;
            points_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.index == rectr_pkg::REG_VOLTAGE_GAIN)
            begin
                gain_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == rectr_pkg::REG_POINTS_IN_USE)
            begin
                points_reg <= cfg.data[rectr_pkg::PIN_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rectr_pkg::ST_IDLE:
            begin
                u_reg      <= item.input_voltage;
                cur_reg    <= item.output_current;
                lo_reg     <= '0;
                hi_reg     <= IW'(n_use - 1'b1);
                nm1_reg    <= IW'(n_use - 1'b1);
                status_reg <= rectr_pkg::RANGE_INSIDE;
                err_reg    <= short_tab;
                r_reg      <= '0;
            end
            rectr_pkg::ST_SRCH_CMP:
            begin
                lo_reg <= lo_nx;
                hi_reg <= hi_nx;
            end
            rectr_pkg::ST_RD_LAST:  below_reg <= (u_reg < rd_v);
            rectr_pkg::ST_RD_LO:
            begin
                if (below_reg)
                begin
                    status_reg <= rectr_pkg::RANGE_BELOW;
                end
                else if (u_reg > rd_v)
                begin
                    status_reg <= rectr_pkg::RANGE_ABOVE;
                end
            end
            rectr_pkg::ST_SEG:
            begin
                rdiff_reg <= $signed(DW'(rd_r)) - $signed(DW'(r0_reg));
                du_reg    <= DW'(u_reg) - DW'(v0_reg);
                dv_reg    <= dv_c;
                if (dv_c == '0)
                begin
                    err_reg <= 1'b1;
                    r_reg   <= r0_reg;
                end
            end
            rectr_pkg::ST_MUL_SEG: prod_reg <= PW'(rdiff_reg) * PW'(du_reg);
            rectr_pkg::ST_DIV_WAIT:
            begin
                if (rsum < 0)
                begin
                    r_reg <= '0;
                end
                else if (rsum > (PW+1)'($signed({1'b0, rectr_pkg::RES_MAX})))
                begin
                    r_reg <= rectr_pkg::RES_MAX;
                end
                else
                begin
                    r_reg <= rsum[RW-1:0];
                end
            end
            rectr_pkg::ST_MUL_G: pg_reg  <= pg_c;
            rectr_pkg::ST_MUL_R: acc_reg <= (AW'(pg_reg) <<< 4) - AW'(prc_c);
            default:
            begin
            end
        endcase
        // entry at the low point, read back in the cycle after its address
        if (state_reg == rectr_pkg::ST_RD_HI)
        begin
            v0_reg <= rd_v;
            r0_reg <= rd_r;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_r_reg      <= r_reg;
            out_seg_reg    <= rectr_pkg::IDX_W'(lo_reg);
            out_status_reg <= status_reg;
            out_err_reg    <= err_reg;
            if (vfull_c > AW'(32'sh7FFFFFFF))
            begin
                out_v_reg   <= 32'sh7FFFFFFF;
                out_sat_reg <= 1'b1;
            end
            else if (vfull_c < -(AW'(1) <<< 31))
            begin
                out_v_reg   <= 32'sh80000000;
                out_sat_reg <= 1'b1;
            end
            else
            begin
                out_v_reg   <= vfull_c[rectr_pkg::OUT_W-1:0];
                out_sat_reg <= 1'b0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.output_voltage  = out_v_reg;
    assign result.resistance_used = out_r_reg;
    assign result.segment_used    = out_seg_reg;
    assign result.range_status    = out_status_reg;
    assign result.table_error     = out_err_reg;
    assign result.saturated       = out_sat_reg;

endmodule

`default_nettype wire

/* design/rectr_checker.sv */
// port-level checks of the rectifier output block, bound to the top level
// depends on rectr_pkg
`default_nettype none

module rectr_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               item_valid,
    input wire logic                               item_ready,
    input wire logic                               item_command,
    input wire logic                               res_valid,
    input wire logic                               res_ready,
    input wire logic signed [rectr_pkg::OUT_W-1:0] res_voltage,
    input wire logic [1:0]                         res_status
);

    // a pending beat stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // a stalled beat keeps its voltage
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_voltage))
        else $error("result beat changed while stalled");

    // compute beat keeps the block busy the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_command == rectr_pkg::CMD_COMPUTE |=> !item_ready)
        else $error("item taken during a compute");

    // a load beat never produces a result on its own
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_command == rectr_pkg::CMD_LOAD
        |=> !$rose(res_valid))
        else $error("result after a load beat");

    // range code is one of the three meanings
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == rectr_pkg::RANGE_INSIDE
                       || res_status == rectr_pkg::RANGE_BELOW
                       || res_status == rectr_pkg::RANGE_ABOVE))
        else $error("bad range code");

endmodule

bind rectifier_output_with_table_resistance rectr_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_command (item.command),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_voltage  (result.output_voltage),
    .res_status   (result.range_status)
);

`default_nettype wire
